// File: hw/rtl/char_word_vm_interpreter_unit_macros.svh
// Assertion macros for the character-word VM interpreter.
// Included by the RTL files that carry concurrent checks.
`ifndef CHAR_WORD_VM_INTERPRETER_UNIT_MACROS_SVH
`define CHAR_WORD_VM_INTERPRETER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define CWVM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cwvm assertion failed");
// Condition must never be true outside reset.
`define CWVM_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cwvm forbidden condition seen");
`else
`define CWVM_ASSERT(lbl, clk, rst_n, prop)
`define CWVM_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// File: hw/rtl/cwvm_pkg.sv
// Shared types, constants and helper functions of the character-word VM.
// No dependencies; imported by every module of the block.
package cwvm_pkg;

  localparam int MEM_WORDS   = 100;
  localparam int PRINT_WORDS = 10;
  localparam int CARD_WORDS  = 10;
  localparam int ADDR_W      = $clog2(MEM_WORDS);
  localparam int CTR_W       = 7;
  localparam int IDX_W       = $clog2(PRINT_WORDS + 1);

  localparam logic [31:0] BLANK_WORD = 32'h2020_2020;

  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_L = 8'h4C;
  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_C = 8'h43;
  localparam logic [7:0] CH_B = 8'h42;
  localparam logic [7:0] CH_G = 8'h47;
  localparam logic [7:0] CH_P = 8'h50;
  localparam logic [7:0] CH_H = 8'h48;
  localparam logic [7:0] CH_R = 8'h52;
  localparam logic [7:0] CH_T = 8'h54;
  localparam logic [7:0] CH_D = 8'h44;

  typedef enum logic [2:0] {
    OP_NEW_JOB   = 3'd0,
    OP_PROG_WORD = 3'd1,
    OP_START     = 3'd2,
    OP_STEP      = 3'd3,
    OP_DATA_WORD = 3'd4,
    OP_NO_DATA   = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_WAIT    = 3'd1,
    ST_PRINT   = 3'd2,
    ST_HALT    = 3'd3,
    ST_NODATA  = 3'd4,
    ST_BADADDR = 3'd5,
    ST_REJECT  = 3'd6
  } status_e;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] char_word;
    logic [2:0]  char_count;
    logic        card_end;
  } item_t;

  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       wdata;
  } mem_req_t;

  // Replace the leading count columns of old with those of w.
  function automatic logic [31:0] merge_chars(logic [31:0] old, logic [31:0] w,
                                              logic [2:0] cnt);
    logic [31:0] m;
    unique case (cnt)
      3'd0:    m = 32'h0000_0000;
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return (old & ~m) | (w & m);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic [3:0] digit_val(logic [7:0] c);
    logic [7:0] t;
    t = c - CH_0;
    return t[3:0];
  endfunction

  // d * 10 as (d << 3) + (d << 1)
  function automatic logic [CTR_W-1:0] times_ten(logic [3:0] d);
    return CTR_W'({d, 3'b000}) + CTR_W'({d, 1'b0});
  endfunction

endpackage

// File: hw/rtl/char_word_vm_interpreter_unit.sv
// Character-word VM interpreter: top level with input buffer, sequencer, word memory.
// Depends on cwvm_pkg, cwvm_word_mem and cwvm_ctrl.
//
// Input channel (in_valid_i / in_stall_o): one op per transfer with its word,
// character count and card-end mark. A one-entry buffer takes the next op while
// the previous op is still being worked or its result still waits.
// Output channel (out_valid_o / out_stall_i): one result per transfer. Every op
// yields one result with last_o set, except a PD that prints ten results with
// last_o on the tenth. The result register holds steady while out_stall_i is high.
// Work per op after the buffer: program/data words read, merge and write; a step
// fetches, decodes and accesses its operand; PD reads and sends each word in turn.
// All are bound by the single memory port. Each result waits for its transfer
// before work goes on; the buffer frees when the sequencer takes the op, so the
// next op can be accepted while the previous one is still being worked.
// Reset (and the new-job op) blanks all 100 words at once through per-word valid
// flops; there is no clearing pass, and an op is taken the cycle after reset.
module char_word_vm_interpreter_unit
  import cwvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] char_word_i,
  input  logic [2:0]  char_count_i,
  input  logic        card_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] out_word_o,
  output logic        last_o,
  output logic [6:0]  counter_now_o,
  output logic        compare_flag_o
);

  logic       buf_valid_q;
  item_t      buf_q;
  logic       take;
  logic       in_xfer;
  mem_req_t   mem_req;
  logic [31:0] mem_rdata;
  status_e    status;

  // Buffer is full or empty; stall only reflects its own flop.
  assign in_stall_o = buf_valid_q;
  assign in_xfer    = in_valid_i && !buf_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
    end else if (in_xfer) begin
      buf_valid_q <= 1'b1;
    end else if (take) begin
      buf_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      buf_q.op         <= op_i;
      buf_q.char_word  <= char_word_i;
      buf_q.char_count <= char_count_i;
      buf_q.card_end   <= card_end_i;
    end
  end

  cwvm_word_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  cwvm_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (buf_valid_q),
    .in_item_i      (buf_q),
    .take_o         (take),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status),
    .out_word_o     (out_word_o),
    .last_o         (last_o),
    .counter_now_o  (counter_now_o),
    .compare_flag_o (compare_flag_o),
    .mem_req_o      (mem_req),
    .mem_rdata_i    (mem_rdata)
  );

  assign status_o = status;

endmodule

// File: hw/rtl/cwvm_word_mem.sv
// Word memory of the VM: one synchronous port, registered read data.
// Per-word valid flops give the blank reset value; depends on cwvm_pkg.
module cwvm_word_mem
  import cwvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mem_req_t    req_i,
  output logic [31:0] rdata_o
);

  logic [31:0]          mem_q [MEM_WORDS];
  logic [MEM_WORDS-1:0] valid_q;
  logic [31:0]          rd_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.addr];
    end
  end

  // Clear drops every word back to blank at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= valid_q[req_i.addr];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rd_q : BLANK_WORD;

endmodule

// File: hw/rtl/cwvm_ctrl.sv
// Sequencer of the VM: decodes ops, runs instructions against the word memory.
// Depends on cwvm_pkg and the assertion macro header.
`include "char_word_vm_interpreter_unit_macros.svh"

module cwvm_ctrl
  import cwvm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  item_t            in_item_i,
  output logic             take_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output status_e          status_o,
  output logic [31:0]      out_word_o,
  output logic             last_o,
  output logic [CTR_W-1:0] counter_now_o,
  output logic             compare_flag_o,
  output mem_req_t         mem_req_o,
  input  logic [31:0]      mem_rdata_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_OPER, S_MERGE, S_PD_RD, S_PD_OUT, S_OUT
  } state_e;

  typedef enum logic [1:0] {
    MODE_IDLE, MODE_RUN, MODE_WAIT, MODE_HALT
  } mode_e;

  localparam logic [CTR_W-1:0] MEM_LIM  = CTR_W'(MEM_WORDS);
  localparam logic [CTR_W-1:0] CARD_LIM = CTR_W'(CARD_WORDS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PRINT_WORDS - 1);

  state_e           state_q;
  mode_e            mode_q;
  status_e          status_q;
  logic             last_q;
  logic [31:0]      pword_q;
  logic [31:0]      gen_q;
  logic [31:0]      ir_q;
  logic [CTR_W-1:0] ctr_q;
  logic             flag_q;
  logic [CTR_W-1:0] load_ptr_q;
  logic [CTR_W-1:0] card_ptr_q;
  logic [CTR_W-1:0] maddr_q;
  logic             is_card_q;
  logic [31:0]      cw_q;
  logic [2:0]       cnt_q;
  logic             cend_q;
  logic [CTR_W-1:0] pd_addr_q;
  logic [IDX_W-1:0] pd_idx_q;
  logic             pd_in_q;

  op_e              item_op;
  logic [7:0]       c0, c1, c2, c3;
  logic             is_lsc, is_bt, is_gd, is_pd, is_h;
  logic [CTR_W-1:0] op_addr, blk_base, card_base;
  logic             addr_ok, blk_ok, card_in;
  logic [2:0]       cur_cnt;
  logic             cur_cend, card_adv;
  logic [CTR_W-1:0] maddr;
  mem_req_t         mem_req;
  logic             mem_acc;
  logic             out_held;

  // Instruction decode works on the word just read from memory.
  always_comb begin
    item_op   = op_e'(in_item_i.op);
    c0        = mem_rdata_i[31:24];
    c1        = mem_rdata_i[23:16];
    c2        = mem_rdata_i[15:8];
    c3        = mem_rdata_i[7:0];
    is_lsc    = (c1 == CH_R) && ((c0 == CH_L) || (c0 == CH_S) || (c0 == CH_C));
    is_bt     = (c0 == CH_B) && (c1 == CH_T);
    is_gd     = (c0 == CH_G) && (c1 == CH_D);
    is_pd     = (c0 == CH_P) && (c1 == CH_D);
    is_h      = (c0 == CH_H);
    op_addr   = times_ten(digit_val(c2)) + CTR_W'(digit_val(c3));
    addr_ok   = is_digit(c2) && is_digit(c3) && (op_addr < MEM_LIM);
    blk_base  = times_ten(digit_val(c2));
    blk_ok    = is_digit(c2) && (blk_base < MEM_LIM);
    // card area comes from the GD instruction still held in ir
    card_base = times_ten(digit_val(ir_q[15:8]));
    card_in   = is_digit(ir_q[15:8]) && (card_base < MEM_LIM) &&
                (card_ptr_q >= card_base) && ((card_ptr_q - card_base) < CARD_LIM) &&
                (card_ptr_q < MEM_LIM);
    cur_cnt   = (state_q == S_IDLE) ? in_item_i.char_count : cnt_q;
    cur_cend  = (state_q == S_IDLE) ? in_item_i.card_end : cend_q;
    card_adv  = (cur_cnt >= 3'd4) && (card_ptr_q < MEM_LIM);
  end

  // Memory port: one read or one write per cycle.
  always_comb begin
    mem_req       = '0;
    mem_req.wdata = gen_q;
    maddr         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (item_op)
            OP_NEW_JOB: mem_req.clr = 1'b1;
            OP_PROG_WORD: begin
              maddr         = load_ptr_q;
              mem_req.rd_en = (load_ptr_q < MEM_LIM);
            end
            OP_STEP: begin
              maddr         = ctr_q;
              mem_req.rd_en = (mode_q == MODE_RUN) && (ctr_q < MEM_LIM);
            end
            OP_DATA_WORD: begin
              maddr         = card_ptr_q;
              mem_req.rd_en = (mode_q == MODE_WAIT) && card_in;
            end
            default: ;
          endcase
        end
      end
      S_DECODE: begin
        if (is_lsc && addr_ok) begin
          maddr = op_addr;
          if (c0 == CH_S) begin
            mem_req.wr_en = 1'b1;
          end else begin
            mem_req.rd_en = 1'b1;
          end
        end
      end
      S_MERGE: begin
        maddr         = maddr_q;
        mem_req.wr_en = 1'b1;
        mem_req.wdata = merge_chars(mem_rdata_i, cw_q, cnt_q);
      end
      S_PD_RD: begin
        maddr         = pd_addr_q;
        mem_req.rd_en = (pd_addr_q < MEM_LIM);
      end
      default: ;
    endcase
    mem_req.addr = maddr[ADDR_W-1:0];
  end

  assign mem_req_o = mem_req;
  assign take_o    = (state_q == S_IDLE) && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      mode_q     <= MODE_IDLE;
      status_q   <= ST_OK;
      last_q     <= 1'b1;
      gen_q      <= BLANK_WORD;
      ir_q       <= BLANK_WORD;
      ctr_q      <= '0;
      flag_q     <= 1'b0;
      load_ptr_q <= '0;
      card_ptr_q <= '0;
      is_card_q  <= 1'b0;
      pd_addr_q  <= '0;
      pd_idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            unique case (item_op)
              OP_NEW_JOB: begin
                mode_q     <= MODE_IDLE;
                gen_q      <= BLANK_WORD;
                ir_q       <= BLANK_WORD;
                ctr_q      <= '0;
                flag_q     <= 1'b0;
                load_ptr_q <= '0;
                card_ptr_q <= '0;
                status_q   <= ST_OK;
                state_q    <= S_OUT;
              end
              OP_PROG_WORD: begin
                if (load_ptr_q >= MEM_LIM) begin
                  status_q <= ST_REJECT;
                  state_q  <= S_OUT;
                end else begin
                  is_card_q <= 1'b0;
                  state_q   <= S_MERGE;
                end
              end
              OP_START: begin
                ctr_q    <= '0;
                mode_q   <= MODE_RUN;
                status_q <= ST_OK;
                state_q  <= S_OUT;
              end
              OP_STEP: begin
                unique case (mode_q)
                  MODE_RUN: begin
                    if (ctr_q >= MEM_LIM) begin
                      mode_q   <= MODE_HALT;
                      status_q <= ST_BADADDR;
                      state_q  <= S_OUT;
                    end else begin
                      state_q <= S_DECODE;
                    end
                  end
                  MODE_WAIT: begin
                    status_q <= ST_WAIT;
                    state_q  <= S_OUT;
                  end
                  MODE_HALT: begin
                    status_q <= ST_HALT;
                    state_q  <= S_OUT;
                  end
                  default: begin
                    status_q <= ST_REJECT;
                    state_q  <= S_OUT;
                  end
                endcase
              end
              OP_DATA_WORD: begin
                if (mode_q != MODE_WAIT) begin
                  status_q <= ST_REJECT;
                  state_q  <= S_OUT;
                end else if (card_in) begin
                  is_card_q <= 1'b1;
                  state_q   <= S_MERGE;
                end else begin
                  // word falls outside the card area: dropped, pointer still moves on a full word
                  if (card_adv) begin
                    card_ptr_q <= card_ptr_q + 1'b1;
                  end
                  if (cur_cend) begin
                    mode_q   <= MODE_RUN;
                    status_q <= ST_OK;
                  end else begin
                    status_q <= ST_WAIT;
                  end
                  state_q <= S_OUT;
                end
              end
              OP_NO_DATA: begin
                if (mode_q != MODE_WAIT) begin
                  status_q <= ST_REJECT;
                end else begin
                  mode_q   <= MODE_HALT;
                  status_q <= ST_NODATA;
                end
                state_q <= S_OUT;
              end
              default: begin
                status_q <= ST_REJECT;
                state_q  <= S_OUT;
              end
            endcase
          end
        end
        S_DECODE: begin
          ir_q  <= mem_rdata_i;
          // a taken branch replaces the increment
          ctr_q <= (is_bt && addr_ok && flag_q) ? op_addr : ctr_q + 1'b1;
          priority if (is_lsc) begin
            if (!addr_ok) begin
              status_q <= ST_BADADDR;
              state_q  <= S_OUT;
            end else if (c0 == CH_S) begin
              status_q <= ST_OK;
              state_q  <= S_OUT;
            end else begin
              state_q <= S_OPER;
            end
          end else if (is_bt) begin
            if (!addr_ok) begin
              status_q <= ST_BADADDR;
            end else begin
              status_q <= ST_OK;
            end
            state_q <= S_OUT;
          end else if (is_gd) begin
            if (!blk_ok) begin
              status_q <= ST_BADADDR;
            end else begin
              card_ptr_q <= blk_base;
              mode_q     <= MODE_WAIT;
              status_q   <= ST_WAIT;
            end
            state_q <= S_OUT;
          end else if (is_pd) begin
            if (!blk_ok) begin
              status_q <= ST_BADADDR;
              state_q  <= S_OUT;
            end else begin
              pd_addr_q <= blk_base;
              pd_idx_q  <= '0;
              state_q   <= S_PD_RD;
            end
          end else if (is_h) begin
            mode_q   <= MODE_HALT;
            status_q <= ST_HALT;
            state_q  <= S_OUT;
          end else begin
            status_q <= ST_OK;
            state_q  <= S_OUT;
          end
        end
        S_OPER: begin
          if (ir_q[31:24] == CH_L) begin
            gen_q <= mem_rdata_i;
          end else begin
            flag_q <= (gen_q == mem_rdata_i);
          end
          status_q <= ST_OK;
          state_q  <= S_OUT;
        end
        S_MERGE: begin
          if (!is_card_q) begin
            if (cnt_q >= 3'd4) begin
              load_ptr_q <= load_ptr_q + 1'b1;
            end
            status_q <= ST_OK;
          end else begin
            if (card_adv) begin
              card_ptr_q <= card_ptr_q + 1'b1;
            end
            if (cend_q) begin
              mode_q   <= MODE_RUN;
              status_q <= ST_OK;
            end else begin
              status_q <= ST_WAIT;
            end
          end
          state_q <= S_OUT;
        end
        S_PD_RD: begin
          state_q <= S_PD_OUT;
        end
        S_PD_OUT: begin
          status_q  <= ST_PRINT;
          last_q    <= (pd_idx_q == IDX_LAST);
          pd_addr_q <= pd_addr_q + 1'b1;
          pd_idx_q  <= pd_idx_q + 1'b1;
          state_q   <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall_i) begin
            state_q <= last_q ? S_IDLE : S_PD_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (take_o) begin
      cw_q    <= in_item_i.char_word;
      cnt_q   <= in_item_i.char_count;
      cend_q  <= in_item_i.card_end;
      maddr_q <= maddr;
    end
    if (state_q == S_PD_RD) begin
      pd_in_q <= (pd_addr_q < MEM_LIM);
    end
    if (state_q == S_PD_OUT) begin
      pword_q <= pd_in_q ? mem_rdata_i : BLANK_WORD;
    end
  end

  assign out_valid_o    = (state_q == S_OUT);
  assign status_o       = status_q;
  assign last_o         = last_q;
  assign out_word_o     = (status_q == ST_PRINT) ? pword_q : gen_q;
  assign counter_now_o  = ctr_q;
  assign compare_flag_o = flag_q;

  assign mem_acc  = mem_req.rd_en || mem_req.wr_en;
  assign out_held = out_valid_o && out_stall_i;

  `CWVM_NEVER(a_no_rd_wr_same_cycle, clk_i, rst_ni, mem_req.rd_en && mem_req.wr_en)
  `CWVM_ASSERT(a_mem_addr_range, clk_i, rst_ni, mem_acc |-> (maddr < MEM_LIM))
  `CWVM_ASSERT(a_state_holds_on_stall, clk_i, rst_ni, out_held |=> $stable({ctr_q, gen_q, flag_q}))
  `CWVM_NEVER(a_only_print_is_not_last, clk_i, rst_ni, out_valid_o && !last_q && status_q != ST_PRINT)
  `CWVM_NEVER(a_card_ptr_bounded, clk_i, rst_ni, card_ptr_q > MEM_LIM)

endmodule

// File: bench/cwvm_result_checker.sv
// Result checker for the character-word VM interpreter: keeps its own copy of the
// machine, predicts the results of every accepted op and compares the output transfers.
// Depends on cwvm_pkg (op and status codes, memory sizes, character constants).
`timescale 1ns / 1ps

module cwvm_result_checker
  import cwvm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  op_i,
  input  logic [31:0] char_word_i,
  input  logic [2:0]  char_count_i,
  input  logic        card_end_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  status_i,
  input  logic [31:0] out_word_i,
  input  logic        last_i,
  input  logic [6:0]  counter_now_i,
  input  logic        compare_flag_i,
  output int          pending_o,
  output logic        awaiting_data_o,
  output int          checked_o,
  output int          errors_o
);

  typedef enum logic [1:0] {
    VM_IDLE = 2'd0,
    VM_RUN  = 2'd1,
    VM_WAIT = 2'd2,
    VM_HALT = 2'd3
  } vm_mode_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] word;
    logic        last;
    logic [6:0]  counter;
    logic        flag;
  } vm_result_t;

  vm_result_t  vm_results_due[$];

  logic [31:0] core_mem [MEM_WORDS];
  logic [31:0] instr_word;
  logic [31:0] acc_word;
  logic [6:0]  pc;
  logic        flag;
  logic [6:0]  load_at;
  logic [6:0]  card_at;
  vm_mode_e    mode;

  int error_tally = 0;
  int checked_tally = 0;

  assign errors_o  = error_tally;
  assign checked_o = checked_tally;

  function automatic logic [31:0] overlay_columns(logic [31:0] old_w, logic [31:0] new_w,
                                                  logic [2:0] cnt);
    logic [31:0] res;
    res = old_w;
    for (int col = 0; col < 4; col++)
      if (col < cnt) res[31-8*col -: 8] = new_w[31-8*col -: 8];
    return res;
  endfunction

  task automatic clear_machine();
    for (int i = 0; i < MEM_WORDS; i++) core_mem[i] = BLANK_WORD;
    instr_word = BLANK_WORD;
    acc_word   = BLANK_WORD;
    pc         = '0;
    flag       = 1'b0;
    load_at    = '0;
    card_at    = '0;
    mode       = VM_IDLE;
  endtask

  task automatic post(status_e st, logic [31:0] w, logic lst);
    vm_results_due.push_back('{status: st, word: w, last: lst, counter: pc, flag: flag});
  endtask

  // card block = tens digit of the current instruction times ten
  task automatic card_block(output logic ok, output int base);
    logic [7:0] c;
    c    = instr_word[15:8];
    ok   = c inside {[CH_0:CH_9]};
    base = (int'(c) - int'(CH_0)) * CARD_WORDS;
    ok   = ok && (base < MEM_WORDS);
  endtask

  task automatic run_instruction();
    logic [7:0] c0, c1, c2, c3;
    logic       addr_ok;
    logic       blk_ok;
    int         addr;
    int         base;
    int         a;
    if (pc >= MEM_WORDS) begin
      mode = VM_HALT;
      post(ST_BADADDR, acc_word, 1'b1);
      return;
    end
    instr_word = core_mem[pc];
    pc = pc + 7'd1;
    {c0, c1, c2, c3} = instr_word;
    addr    = (int'(c2) - int'(CH_0)) * 10 + int'(c3) - int'(CH_0);
    addr_ok = (c2 inside {[CH_0:CH_9]}) && (c3 inside {[CH_0:CH_9]}) && (addr < MEM_WORDS);

    if (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) begin
      if (!addr_ok) begin
        post(ST_BADADDR, acc_word, 1'b1);
        return;
      end
      case (c0)
        CH_L:    acc_word = core_mem[addr];
        CH_S:    core_mem[addr] = acc_word;
        default: flag = (acc_word == core_mem[addr]);
      endcase
    end else if (c0 == CH_B && c1 == CH_T) begin
      if (!addr_ok) begin
        post(ST_BADADDR, acc_word, 1'b1);
        return;
      end
      if (flag) pc = 7'(addr);
    end else if ((c0 == CH_G || c0 == CH_P) && c1 == CH_D) begin
      card_block(blk_ok, base);
      if (!blk_ok) begin
        post(ST_BADADDR, acc_word, 1'b1);
        return;
      end
      if (c0 == CH_G) begin
        card_at = 7'(base);
        mode    = VM_WAIT;
        post(ST_WAIT, acc_word, 1'b1);
      end else begin
        for (int i = 0; i < PRINT_WORDS; i++) begin
          a = base + i;
          post(ST_PRINT, (a < MEM_WORDS) ? core_mem[a] : BLANK_WORD, i == PRINT_WORDS - 1);
        end
      end
      return;
    end else if (c0 == CH_H) begin
      mode = VM_HALT;
      post(ST_HALT, acc_word, 1'b1);
      return;
    end
    // undecoded words fall through here as a no-op
    post(ST_OK, acc_word, 1'b1);
  endtask

  task automatic interpret_op(logic [2:0] op, logic [31:0] w, logic [2:0] cnt, logic cend);
    logic blk_ok;
    int   base;
    case (op)
      OP_NEW_JOB: begin
        clear_machine();
        post(ST_OK, acc_word, 1'b1);
      end
      OP_PROG_WORD: begin
        if (load_at >= MEM_WORDS) begin
          post(ST_REJECT, acc_word, 1'b1);
        end else begin
          core_mem[load_at] = overlay_columns(core_mem[load_at], w, cnt);
          if (cnt >= 3'd4) load_at = load_at + 7'd1;
          post(ST_OK, acc_word, 1'b1);
        end
      end
      OP_START: begin
        pc   = '0;
        mode = VM_RUN;
        post(ST_OK, acc_word, 1'b1);
      end
      OP_STEP: begin
        case (mode)
          VM_RUN:  run_instruction();
          VM_WAIT: post(ST_WAIT, acc_word, 1'b1);
          VM_HALT: post(ST_HALT, acc_word, 1'b1);
          default: post(ST_REJECT, acc_word, 1'b1);
        endcase
      end
      OP_DATA_WORD: begin
        if (mode != VM_WAIT) begin
          post(ST_REJECT, acc_word, 1'b1);
        end else begin
          card_block(blk_ok, base);
          // words past the ten-word block are dropped, the pointer still moves on a full word
          if (blk_ok && card_at >= base && card_at - base < CARD_WORDS && card_at < MEM_WORDS)
            core_mem[card_at] = overlay_columns(core_mem[card_at], w, cnt);
          if (cnt >= 3'd4 && card_at < MEM_WORDS) card_at = card_at + 7'd1;
          if (cend) begin
            mode = VM_RUN;
            post(ST_OK, acc_word, 1'b1);
          end else begin
            post(ST_WAIT, acc_word, 1'b1);
          end
        end
      end
      OP_NO_DATA: begin
        if (mode != VM_WAIT) begin
          post(ST_REJECT, acc_word, 1'b1);
        end else begin
          mode = VM_HALT;
          post(ST_NODATA, acc_word, 1'b1);
        end
      end
      default: post(ST_REJECT, acc_word, 1'b1);
    endcase
  endtask

  task automatic compare_field(string field, logic [31:0] due_v, logic [31:0] got_v);
    if (got_v !== due_v) begin
      $error("%s mismatch: expected %h, got %h", field, due_v, got_v);
      error_tally++;
    end
  endtask

  task automatic check_result();
    vm_result_t due;
    if (vm_results_due.size() == 0) begin
      $error("result with nothing pending: status %0d word %h", status_i, out_word_i);
      error_tally++;
      return;
    end
    due = vm_results_due.pop_front();
    checked_tally++;
    compare_field("status", 32'(due.status), 32'(status_i));
    compare_field("out_word", due.word, out_word_i);
    compare_field("last", 32'(due.last), 32'(last_i));
    compare_field("counter_now", 32'(due.counter), 32'(counter_now_i));
    compare_field("compare_flag", 32'(due.flag), 32'(compare_flag_i));
  endtask

  // Output is compared before the input is modeled: a result can never come from
  // an op accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_machine();
      vm_results_due.delete();
      pending_o       <= 0;
      awaiting_data_o <= 1'b0;
    end else begin
      if (out_valid_i && !out_stall_i) check_result();
      if (in_valid_i && !in_stall_i) interpret_op(op_i, char_word_i, char_count_i, card_end_i);
      pending_o       <= vm_results_due.size();
      awaiting_data_o <= (mode == VM_WAIT);
    end
  end

endmodule

// File: bench/tb_top.sv
// Top of the VM interpreter bench: clock, reset, op stimulus, output stall and verdict.
// Depends on cwvm_pkg, char_word_vm_interpreter_unit and cwvm_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import cwvm_pkg::*;

  // op code left undefined by the block
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_OPS    = 110;
  // Longest legal quiet spell is a PD's work under a 68 % receiver stall, or a
  // drain pause; HANG_LIMIT idle cycles is far beyond either.
  localparam int HANG_LIMIT    = 2000;
  // PD is the longest op, and SETTLE_CYCLES covers it twice
  localparam int SETTLE_CYCLES = 64;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_op = OP_NEW_JOB;
  logic [31:0] in_word = '0;
  logic [2:0]  in_count = '0;
  logic        in_card_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_word;
  logic        out_last;
  logic [6:0]  out_counter;
  logic        out_flag;

  int          pending;
  logic        awaiting_data;
  int          checked;
  int          errors;

  // flow-control profile, changed between phases
  int          send_idle_pct = 20;
  int          stall_pct = 68;
  int          stuck_cycles = 0;
  int          op_tally [8];
  int          op_total = 0;

  always #10 clk = ~clk;

  char_word_vm_interpreter_unit dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .op_i          (in_op),
    .char_word_i   (in_word),
    .char_count_i  (in_count),
    .card_end_i    (in_card_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (out_status),
    .out_word_o    (out_word),
    .last_o        (out_last),
    .counter_now_o (out_counter),
    .compare_flag_o(out_flag)
  );

  cwvm_result_checker result_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .op_i           (in_op),
    .char_word_i    (in_word),
    .char_count_i   (in_count),
    .card_end_i     (in_card_end),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .status_i       (out_status),
    .out_word_i     (out_word),
    .last_i         (out_last),
    .counter_now_i  (out_counter),
    .compare_flag_i (out_flag),
    .pending_o      (pending),
    .awaiting_data_o(awaiting_data),
    .checked_o      (checked),
    .errors_o       (errors)
  );

  // Receiver side: random stall at the current rate.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= HANG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d results pending",
               stuck_cycles, pending);
      $display("FAILURE");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Present one op and hold it until the transfer. Called at a clock edge;
  // returns at the edge where the op was taken, so the next call can keep valid high.
  task automatic send_op(logic [2:0] op, logic [31:0] word, logic [2:0] cnt, logic cend);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_word     <= word;
    in_count    <= cnt;
    in_card_end <= cend;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    op_tally[op]++;
    op_total++;
  endtask

  // Hold off the sender until every predicted result has been seen.
  // The extra edge lets the checker's count catch up with the last transfer.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly full words; now and then any count from zero to seven.
  function automatic logic [2:0] pick_count();
    return ($urandom_range(4) == 0) ? 3'($urandom_range(7)) : 3'd4;
  endfunction

  function automatic logic [31:0] encode_instr(logic [7:0] c0, logic [7:0] c1, int num);
    return {c0, c1, 8'(int'(CH_0) + num / 10), 8'(int'(CH_0) + num % 10)};
  endfunction

  // Random instruction; branches aim at the program, GD blocks stay clear of
  // programs under twenty words, and a small share carries a broken operand.
  function automatic logic [31:0] random_instr(int prog_len);
    logic [7:0] c0, c1;
    int         target;
    target = $urandom_range(MEM_WORDS - 1);
    case ($urandom_range(9))
      0:       begin c0 = CH_L; c1 = CH_R; end
      1:       begin c0 = CH_S; c1 = CH_R; end
      2, 3:    begin c0 = CH_C; c1 = CH_R; end
      4:       begin c0 = CH_B; c1 = CH_T; target = $urandom_range(prog_len - 1); end
      5:       begin c0 = CH_G; c1 = CH_D; target = 10 * $urandom_range(2, 9); end
      6:       begin c0 = CH_P; c1 = CH_D; target = 10 * $urandom_range(9); end
      7:       begin c0 = CH_H; c1 = 8'($urandom); end
      8:       return $urandom();
      default: begin c0 = CH_L; c1 = CH_R; end
    endcase
    if ($urandom_range(19) == 0) return {c0, c1, 8'($urandom), 8'($urandom)};
    return encode_instr(c0, c1, target);
  endfunction

  // Answer a pending GD: a short card, sometimes one that overruns its block,
  // sometimes the end of input instead.
  task automatic feed_card();
    int n;
    if ($urandom_range(7) == 0) begin
      send_op(OP_NO_DATA, $urandom(), 3'($urandom), 1'($urandom));
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(11, 13) : $urandom_range(1, 4);
    for (int k = 0; k < n; k++)
      send_op(OP_DATA_WORD, $urandom(), pick_count(), k == n - 1);
  endtask

  // One job: clear, load a program, start, then single-step it. The awaiting
  // flag from the checker lags by one op, so a GD is first seen as a step that
  // reports waiting, and the card follows.
  task automatic run_job(int words);
    int steps;
    send_op(OP_NEW_JOB, $urandom(), 3'($urandom), 1'($urandom));
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(15) == 0)
        send_op(OP_PROG_WORD, $urandom(), 3'($urandom_range(3)), 1'($urandom));
      if (i == words - 1 && $urandom_range(9) < 7)
        send_op(OP_PROG_WORD, "H   ", 3'd4, 1'($urandom));
      else
        send_op(OP_PROG_WORD, random_instr(words),
                ($urandom_range(3) == 0) ? 3'($urandom_range(5, 7)) : 3'd4, 1'($urandom));
    end
    send_op(OP_START, $urandom(), 3'($urandom), 1'($urandom));
    steps = ((words < 16) ? words : 16) + $urandom_range(2, 10);
    for (int s = 0; s < steps; s++) begin
      if (awaiting_data)
        feed_card();
      else if ($urandom_range(11) == 0)
        send_op(3'($urandom_range(1, 7)), $urandom(), 3'($urandom), 1'($urandom));
      send_op(OP_STEP, $urandom(), 3'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int  directed_ops;
    int  profile;
    bit  memory_filled;
    profile       = 0;
    memory_filled = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed job: undefined op, partial and zero-count loads, an oversized
    // count, a card with a partial word, a step while waiting, every operand
    // type, a bad operand, a taken branch near the top of memory, and the
    // counter running off the end followed by a step on a halted job.
    send_op(OP_SPARE_7, 32'hFFFF_FFFF, 3'd7, 1'b1);
    send_op(OP_NEW_JOB, 32'h0000_0000, 3'd0, 1'b0);
    send_op(OP_PROG_WORD, "GD9Z", 3'd2, 1'b0);   // only "GD" lands, pointer holds
    send_op(OP_PROG_WORD, "XXXX", 3'd0, 1'b0);   // nothing written
    send_op(OP_PROG_WORD, "GD30", 3'd7, 1'b0);   // acts as a full word
    send_op(OP_PROG_WORD, "LR31", 3'd4, 1'b1);
    send_op(OP_PROG_WORD, "CR31", 3'd4, 1'b0);
    send_op(OP_PROG_WORD, "PD30", 3'd4, 1'b0);
    send_op(OP_PROG_WORD, "SR9A", 3'd4, 1'b0);   // operand not a digit
    send_op(OP_PROG_WORD, "BT98", 3'd4, 1'b0);
    send_op(OP_START, 32'hFFFF_FFFF, 3'd4, 1'b1);
    send_op(OP_STEP, 32'h0, 3'd4, 1'b0);         // GD30
    send_op(OP_STEP, 32'h0, 3'd4, 1'b0);         // still waiting for the card
    send_op(OP_DATA_WORD, "AB??", 3'd2, 1'b0);
    send_op(OP_DATA_WORD, "WXYZ", 3'd5, 1'b0);
    send_op(OP_DATA_WORD, "1234", 3'd4, 1'b1);
    // LR31, CR31 (equal, flag set), PD30, SR9A, BT98 taken,
    // blank words at 98 and 99, counter past memory, halted
    repeat (9) send_op(OP_STEP, $urandom(), 3'($urandom), 1'($urandom));
    directed_ops = op_total;
    drain();

    while (op_total - directed_ops < RANDOM_OPS) begin
      if (profile == 0 && op_total - directed_ops >= RANDOM_OPS / 3) begin
        profile = 1;
        drain();
        send_idle_pct = 68;
        stall_pct     = 20;
      end else if (profile == 1 && op_total - directed_ops >= 2 * RANDOM_OPS / 3) begin
        profile = 2;
        drain();
        send_idle_pct = 0;
        stall_pct     = 0;
      end else if ($urandom_range(5) == 0) begin
        drain();
      end
      // one job overfills memory so the last program words get rejected
      if (profile == 2 && !memory_filled) begin
        memory_filled = 1'b1;
        run_job(MEM_WORDS + 2);
      end else begin
        run_job($urandom_range(3, 14));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Ran %0d ops (%0d jobs, %0d program words, %0d steps, %0d data words),",
             op_total, op_tally[OP_NEW_JOB], op_tally[OP_PROG_WORD], op_tally[OP_STEP],
             op_tally[OP_DATA_WORD]);
    $display("%0d results checked under three idle/stall profiles, with a full-memory load",
             checked);
    $display("and a run off the end of memory.");
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
